// File: src/mas_pkg.sv
// Shared types, constants and calibration tables of the meter autorange scaler.
package mas_pkg;

  localparam int unsigned DEF_ADC_BITS  = 16;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned THR_W     = 30;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned READ_W    = 32;
  localparam int unsigned CAL_MUL_W = 21;
  localparam int unsigned CAL_DIV_W = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONT    = 3'd4;

  typedef enum logic [1:0] {
    MODE_VOLT = 2'd0,
    MODE_AMP  = 2'd1,
    MODE_OHM  = 2'd2,
    MODE_CONT = 2'd3
  } mode_e;

  // Range codes
  localparam logic [1:0] RANGE_NONE = 2'd0;
  localparam logic [1:0] RANGE_1    = 2'd1;
  localparam logic [1:0] RANGE_2    = 2'd2;
  localparam logic [1:0] RANGE_3    = 2'd3;

  // Front-end control bytes
  localparam logic [7:0] FE_1V    = 8'b1100_0010;
  localparam logic [7:0] FE_5V    = 8'b1100_0100;
  localparam logic [7:0] FE_15V   = 8'b1100_0000;
  localparam logic [7:0] FE_10MA  = 8'b1101_0001;
  localparam logic [7:0] FE_200MA = 8'b1101_0110;

  typedef enum logic [2:0] {
    CAL_V1,
    CAL_V5,
    CAL_V15,
    CAL_A10,
    CAL_A200,
    CAL_OHM,
    CAL_CONT
  } cal_e;

  // Calibration as floor((OFF - MUL*v) / DIV); slope, scale and the doubling
  // of round-to-nearest are folded into MUL and OFF.
  function automatic logic [CAL_MUL_W-1:0] cal_mul(cal_e c);
    logic [CAL_MUL_W-1:0] m;
    case (c)
      CAL_V1:   m = 21'd1448;
      CAL_V5:   m = 21'd7312;
      CAL_V15:  m = 21'd193362;
      CAL_A10:  m = 21'd13900;
      CAL_A200: m = 21'd635400;
      CAL_OHM:  m = 21'd1492146;
      default:  m = 21'd135284;
    endcase
    return m;
  endfunction

  function automatic logic [CAL_DIV_W-1:0] cal_div(cal_e c);
    logic [CAL_DIV_W-1:0] d;
    case (c)
      CAL_V1:   d = 15'd2000;
      CAL_V5:   d = 15'd2000;
      CAL_V15:  d = 15'd20000;
      CAL_A10:  d = 15'd1964;
      CAL_A200: d = 15'd4908;
      CAL_OHM:  d = 15'd2000;
      default:  d = 15'd20000;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] cal_off(cal_e c, int unsigned frac);
    logic [63:0] b;
    case (c)
      CAL_V1:   b = 64'd2382;
      CAL_V5:   b = 64'd12064;
      CAL_V15:  b = 64'd318260;
      CAL_A10:  b = 64'd23100;
      CAL_A200: b = 64'd1048200;
      CAL_OHM:  b = 64'd2454930;
      default:  b = 64'd197572;
    endcase
    return (b << frac) + (64'(cal_div(c)) >> 1);
  endfunction

  typedef struct packed {
    logic start_vdiv;
    logic load_v;
    logic load_prod;
    logic load_dvd;
    logic start_cdiv;
    logic load_val;
    logic commit;
  } mas_cmd_t;

  typedef struct packed {
    logic div_done;
  } mas_stat_t;

  typedef struct packed {
    logic [CODE_W-1:0] adc_code;
  } mas_in_t;

  typedef struct packed {
    logic signed [READ_W-1:0] reading;
    logic [1:0]               range_code;
    logic [7:0]               frontend_word;
    logic                     frontend_load;
    logic                     buzzer_on;
  } mas_out_t;

endpackage

// File: src/mas_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface mas_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/mas_div.sv
// Constant divider by reciprocal multiplication, one 16-bit reciprocal digit per cycle.
module mas_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned MW = 51,
  parameter int unsigned KS = 61,
  parameter int unsigned QW = 29
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [MW-1:0] recip_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  localparam int unsigned DGW = 16;
  localparam int unsigned ND  = (MW + DGW - 1) / DGW;
  localparam int unsigned RW  = ND * DGW;
  localparam int unsigned AW  = NW + RW;
  localparam int unsigned PW  = NW + DGW;
  localparam int unsigned CW  = $clog2(ND + 1);

  logic [NW-1:0] dvd_q, dvd_d;
  logic [RW-1:0] rcp_q, rcp_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [PW-1:0] part;

  // quotient = (dividend * reciprocal) >> KS; reciprocal digits taken high first
  always_comb begin
    part = PW'(dvd_q) * PW'(rcp_q[RW-1 -: DGW]);

    dvd_d  = dvd_q;
    rcp_d  = rcp_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rcp_d = RW'(recip_i);
      acc_d = '0;
      cnt_d = CW'(ND);
    end else if (cnt_q != '0) begin
      acc_d  = (acc_q << DGW) + AW'(part);
      rcp_d  = rcp_q << DGW;
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rcp_q <= rcp_d;
    acc_q <= acc_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q[KS +: QW];

endmodule

// File: src/mas_datapath.sv
// Datapath: configuration, scaling, calibration, saturation, autorange state, result register.
module mas_datapath import mas_pkg::*; #(
  parameter int unsigned ADC_BITS  = DEF_ADC_BITS,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CODE_W-1:0]    adc_code_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_wdata_i,
  input  mas_cmd_t             cmd_i,
  output mas_stat_t            stat_o,
  output mas_out_t             result_o
);

  localparam int unsigned VW = FRAC_BITS + 2;
  localparam int unsigned QW = FRAC_BITS + 13;
  localparam int unsigned NW = (ADC_BITS + 7 > 24) ? FRAC_BITS + ADC_BITS + 7 : FRAC_BITS + 24;
  localparam int unsigned YW = (ADC_BITS + 5 > CAL_DIV_W) ? ADC_BITS + 5 : CAL_DIV_W;
  localparam int unsigned PW = VW + CAL_MUL_W;
  localparam int unsigned SW = (QW + 1 > READ_W) ? QW + 1 : READ_W + 1;
  // reciprocal scale: exact floor for any dividend below 2^NW and divisor below 2^YW
  localparam int unsigned KS = NW + YW;
  // every divisor is above 2^10, so each reciprocal fits in KS-10 bits
  localparam int unsigned MW = KS - 10;

  localparam logic [63:0]    ADC_MAX  = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [63:0]    ONE      = 64'd1 << FRAC_BITS;
  localparam logic [NW-1:0]  V_OFF    = NW'(64'd10 * ADC_MAX);
  localparam logic [YW-1:0]  V_DIV    = YW'(64'd20 * ADC_MAX);
  localparam logic [THR_W-1:0] VLO_RST  = THR_W'((64'd18 * ONE + 64'd10) / 64'd20);
  localparam logic [THR_W-1:0] VHI_RST  = THR_W'((64'd38 * ONE + 64'd4) / 64'd8);
  localparam logic [THR_W-1:0] CURR_RST = THR_W'(64'd10 * ONE);
  localparam logic [THR_W-1:0] CONT_RST = THR_W'(64'd5 * ONE);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW - READ_W + 1){1'b0}}, {(READ_W - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW - READ_W + 1){1'b1}}, {(READ_W - 1){1'b0}}};

  // reciprocals ceil(2^KS / divisor) of the scaling and calibration divisors
  localparam logic [127:0]  K_POW    = 128'd1 << KS;
  localparam logic [MW-1:0] RCP_VOLT = MW'((K_POW + 128'(V_DIV) - 128'd1) / 128'(V_DIV));
  localparam logic [MW-1:0] RCP_V1   = MW'((K_POW + 128'(cal_div(CAL_V1)) - 128'd1)
                                           / 128'(cal_div(CAL_V1)));
  localparam logic [MW-1:0] RCP_V5   = MW'((K_POW + 128'(cal_div(CAL_V5)) - 128'd1)
                                           / 128'(cal_div(CAL_V5)));
  localparam logic [MW-1:0] RCP_V15  = MW'((K_POW + 128'(cal_div(CAL_V15)) - 128'd1)
                                           / 128'(cal_div(CAL_V15)));
  localparam logic [MW-1:0] RCP_A10  = MW'((K_POW + 128'(cal_div(CAL_A10)) - 128'd1)
                                           / 128'(cal_div(CAL_A10)));
  localparam logic [MW-1:0] RCP_A200 = MW'((K_POW + 128'(cal_div(CAL_A200)) - 128'd1)
                                           / 128'(cal_div(CAL_A200)));
  localparam logic [MW-1:0] RCP_OHM  = MW'((K_POW + 128'(cal_div(CAL_OHM)) - 128'd1)
                                           / 128'(cal_div(CAL_OHM)));
  localparam logic [MW-1:0] RCP_CONT = MW'((K_POW + 128'(cal_div(CAL_CONT)) - 128'd1)
                                           / 128'(cal_div(CAL_CONT)));

  // configuration and autorange state
  mode_e            mode_q;
  logic [THR_W-1:0] volt_lo_q, volt_hi_q, curr_thr_q, cont_thr_q;
  logic [1:0]       vsel_q, vsel_d;
  logic [1:0]       asel_q, asel_d;
  logic             buzz_q, buzz_d;

  // per-item working registers
  logic [VW-1:0]        v_q;
  cal_e                 cal_q, cal_d;
  logic [PW-1:0]        prod_q;
  logic [NW-1:0]        cdvd_q, cdvd_d;
  logic                 neg_q, neg_d;
  logic [CAL_DIV_W-1:0] cdiv_q;
  logic [MW-1:0]        rcp_q, rcp_sel;
  logic signed [READ_W-1:0] val_q, val_d;
  mas_out_t             res_q, res_d;

  logic [ADC_BITS-1:0]  code;
  logic [NW-1:0]        vdvd;
  logic [NW-1:0]        xs, mag;
  logic                 div_start, div_done;
  logic [NW-1:0]        div_dvd;
  logic [MW-1:0]        div_rcp;
  logic [QW-1:0]        quo;
  logic signed [SW-1:0] q_ext, s_val;
  logic signed [READ_W:0] val_x, lo_x, hi_x, curr_x, cont_x;

  // scaled sample: floor((2*code*33*R + D) / 2D), D = 10 * full scale
  assign code = ADC_BITS'(adc_code_i);
  assign vdvd = ((((NW'(code) << 6) + (NW'(code) << 1))) << FRAC_BITS) + V_OFF;

  assign div_start = cmd_i.start_vdiv | cmd_i.start_cdiv;
  assign div_dvd   = cmd_i.start_vdiv ? vdvd : cdvd_q;
  assign div_rcp   = cmd_i.start_vdiv ? RCP_VOLT : rcp_q;

  mas_div #(
    .NW (NW),
    .MW (MW),
    .KS (KS),
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .recip_i    (div_rcp),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign stat_o.div_done = div_done;

  // calibration choice for the current mode and range
  always_comb begin
    case (mode_q)
      MODE_VOLT: cal_d = (vsel_q == RANGE_1) ? CAL_V1 : (vsel_q == RANGE_2) ? CAL_V5 : CAL_V15;
      MODE_AMP:  cal_d = (asel_q == RANGE_1) ? CAL_A10 : CAL_A200;
      MODE_OHM:  cal_d = CAL_OHM;
      default:   cal_d = CAL_CONT;
    endcase
  end

  always_comb begin
    case (cal_d)
      CAL_V1:   rcp_sel = RCP_V1;
      CAL_V5:   rcp_sel = RCP_V5;
      CAL_V15:  rcp_sel = RCP_V15;
      CAL_A10:  rcp_sel = RCP_A10;
      CAL_A200: rcp_sel = RCP_A200;
      CAL_OHM:  rcp_sel = RCP_OHM;
      default:  rcp_sel = RCP_CONT;
    endcase
  end

  // signed floor division turned into an unsigned one on the magnitude
  always_comb begin
    xs     = NW'(cal_off(cal_q, FRAC_BITS)) - NW'(prod_q);
    neg_d  = xs[NW-1];
    mag    = neg_d ? (~xs + NW'(1)) : xs;
    cdvd_d = neg_d ? mag + NW'(cdiv_q) - NW'(1) : mag;
  end

  always_comb begin
    q_ext = $signed(SW'(quo));
    s_val = neg_q ? -q_ext : q_ext;
    if (s_val > SAT_MAX) begin
      val_d = READ_W'(SAT_MAX);
    end else if (s_val < SAT_MIN) begin
      val_d = READ_W'(SAT_MIN);
    end else begin
      val_d = READ_W'(s_val);
    end
  end

  // autorange, buzzer and result word
  always_comb begin
    val_x  = {val_q[READ_W-1], val_q};
    lo_x   = $signed({3'b000, volt_lo_q});
    hi_x   = $signed({3'b000, volt_hi_q});
    curr_x = $signed({3'b000, curr_thr_q});
    cont_x = $signed({3'b000, cont_thr_q});
    vsel_d = vsel_q;
    asel_d = asel_q;
    buzz_d = buzz_q;
    res_d  = '0;
    res_d.reading = val_q;
    case (mode_q)
      MODE_VOLT: begin
        res_d.range_code = vsel_q;
        // checks run in order, so 1 V may step straight to 15 V
        if (vsel_d == RANGE_1 && val_x > lo_x) vsel_d = RANGE_2;
        if (vsel_d == RANGE_2 && val_x < lo_x) vsel_d = RANGE_1;
        if (vsel_d == RANGE_2 && val_x > hi_x) vsel_d = RANGE_3;
        if (vsel_d == RANGE_3 && val_x < hi_x) vsel_d = RANGE_2;
        res_d.frontend_word = (vsel_d == RANGE_1) ? FE_1V : (vsel_d == RANGE_2) ? FE_5V : FE_15V;
        res_d.frontend_load = 1'b1;
      end
      MODE_AMP: begin
        res_d.range_code = asel_q;
        if (asel_q == RANGE_1 && val_x > curr_x) begin
          asel_d = RANGE_2;
        end else if (asel_q == RANGE_2 && val_x < curr_x) begin
          asel_d = RANGE_1;
        end
        res_d.frontend_word = (asel_d == RANGE_1) ? FE_10MA : FE_200MA;
        res_d.frontend_load = 1'b1;
      end
      MODE_CONT: begin
        buzz_d = (val_x < cont_x);
      end
      default: begin
        res_d.range_code = RANGE_NONE;
      end
    endcase
    res_d.buzzer_on = buzz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_VOLT;
      volt_lo_q  <= VLO_RST;
      volt_hi_q  <= VHI_RST;
      curr_thr_q <= CURR_RST;
      cont_thr_q <= CONT_RST;
      vsel_q     <= RANGE_3;
      asel_q     <= RANGE_2;
      buzz_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q     <= mode_e'(cfg_wdata_i[1:0]);
          REG_VOLT_LO: volt_lo_q  <= cfg_wdata_i;
          REG_VOLT_HI: volt_hi_q  <= cfg_wdata_i;
          REG_CURR:    curr_thr_q <= cfg_wdata_i;
          REG_CONT:    cont_thr_q <= cfg_wdata_i;
          default:     ;
        endcase
      end
      if (cmd_i.commit) begin
        vsel_q <= vsel_d;
        asel_q <= asel_d;
        buzz_q <= buzz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_v) begin
      v_q    <= VW'(quo);
      cal_q  <= cal_d;
      cdiv_q <= cal_div(cal_d);
      rcp_q  <= rcp_sel;
    end
    if (cmd_i.load_prod) begin
      prod_q <= PW'(v_q) * PW'(cal_mul(cal_q));
    end
    if (cmd_i.load_dvd) begin
      cdvd_q <= cdvd_d;
      neg_q  <= neg_d;
    end
    if (cmd_i.load_val) begin
      val_q <= val_d;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

// File: src/mas_ctrl.sv
// Controller: sequences one sample through the datapath and owns the output valid.
module mas_ctrl import mas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mas_cmd_t  cmd_o,
  input  mas_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VDIV,
    S_MUL,
    S_PREP,
    S_CSTART,
    S_CDIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start_vdiv = 1'b1;
          state_d          = S_VDIV;
        end
      end
      S_VDIV: begin
        if (stat_i.div_done) begin
          cmd_o.load_v = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d         = S_PREP;
      end
      S_PREP: begin
        cmd_o.load_dvd = 1'b1;
        state_d        = S_CSTART;
      end
      S_CSTART: begin
        cmd_o.start_cdiv = 1'b1;
        state_d          = S_CDIV;
      end
      S_CDIV: begin
        if (stat_i.div_done) begin
          cmd_o.load_val = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/meter_autorange_scaler_top.sv
// Meter autorange scaler: ADC sample to calibrated reading with range and buzzer control.
// A sample passes, for 16-bit codes and Q16.16, through two reciprocal multiplies of
// 4 digits each, one digit per cycle, and through the controller's sequencing states.
// Input is taken only while the sequencer is idle, once the last result has been committed.
// A finished result waits in the output register; a stalled output delays the next commit.
// Reset (async, active low): voltmeter, default thresholds, 15 V and 200 mA, buzzer off.
module meter_autorange_scaler_top import mas_pkg::*; #(
  parameter int unsigned ADC_BITS  = DEF_ADC_BITS,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mas_stream_if.sink           in_i,
  mas_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_wdata_i
);

  mas_cmd_t  cmd;
  mas_stat_t stat;
  mas_out_t  result;

  // Sequencer: takes a transfer only when idle, drives the output valid
  mas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Arithmetic, configuration registers and range state
  mas_datapath #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adc_code_i  (in_i.data.adc_code),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result)
  );

  // Result register drives the output payload directly
  assign out_o.data = result;

endmodule
